### sv/double_operand_mov_cmp_execute_top_defines.svh
// Assertion macros for the MOV/CMP execution unit.
`ifndef DOUBLE_OPERAND_MOV_CMP_EXECUTE_TOP_DEFINES_SVH
`define DOUBLE_OPERAND_MOV_CMP_EXECUTE_TOP_DEFINES_SVH
// Check that a property holds on every edge outside reset.
`define DOMC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check that a property holds on every edge, reset included.
`define DOMC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

### sv/domc_pkg.sv
// ----------------------------------------------------------------------------
// domc_pkg
// Shared types and constants for the MOV/CMP execution unit.
// ----------------------------------------------------------------------------
`default_nettype none
package domc_pkg;
  localparam int MemWordsDefault = 32768;

  localparam logic [1:0] CmdMov  = 2'd0;
  localparam logic [1:0] CmdCmp  = 2'd1;
  localparam logic [1:0] CmdLdm  = 2'd2;
  localparam logic [1:0] CmdLdr  = 2'd3;

  localparam logic [2:0] RegPc = 3'd7;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRC_EA,
    ST_SRC_IDX,
    ST_SRC_PTR,
    ST_SRC_OPND,
    ST_DST_EA,
    ST_DST_IDX,
    ST_DST_PTR,
    ST_DST_OPND,
    ST_FINISH,
    ST_ERR,
    ST_WAIT
  } state_t;

  // controller commands to the datapath
  typedef struct packed {
    logic       load_cmd;   // capture the command word
    logic       ea_start;   // begin operand: resolve mode
    logic       dst_side;   // 0 source, 1 destination
    logic       idx_fetch;  // read index word at PC
    logic       ptr_fetch;  // read pointer at addr
    logic       opnd_fetch; // read operand at addr
    logic       finish;     // commit and emit
    logic       error;      // emit error
  } ctl_t;

  // datapath status to the controller
  typedef struct packed {
    logic [1:0] cmd;
    logic [2:0] mode;      // mode of the active side
    logic       odd;       // address about to be used is odd
  } sts_t;
endpackage
`default_nettype wire

### sv/double_operand_mov_cmp_execute_top.sv
// A MOV or CMP reads memory through the single registered memory port, one
// read (index word, pointer, operand) at a time, each followed by ST_WAIT;
// each operand also has an address-forming state, and a commit state ends
// the command, so a deferred indexed source and destination is the longest
// case. Loads go from the address state straight to commit. done pulses for one cycle with the result word
// and the flags; the receiver cannot stall, so sample it when it appears.
// ----------------------------------------------------------------------------
// double_operand_mov_cmp_execute_top
// Word MOV/CMP execution unit with eight addressing modes.
// ----------------------------------------------------------------------------
`default_nettype none
`include "double_operand_mov_cmp_execute_top_defines.svh"
module double_operand_mov_cmp_execute_top #(
  parameter int MEM_WORDS = domc_pkg::MemWordsDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  cmd,
  input  wire logic [2:0]  src_mode,
  input  wire logic [2:0]  src_reg,
  input  wire logic [2:0]  dst_mode,
  input  wire logic [2:0]  dst_reg,
  input  wire logic [15:0] load_address,
  input  wire logic [15:0] load_data,
  output logic             done,
  output logic             status,
  output logic [15:0]      value,
  output logic             flag_n,
  output logic             flag_z,
  output logic             flag_v,
  output logic             flag_c
);
  domc_pkg::ctl_t ctl;
  domc_pkg::sts_t sts;

  domc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .sts(sts), .ctl(ctl)
  );

  domc_dpath #(.MEM_WORDS(MEM_WORDS)) u_dpath (
    .clk(clk), .rst(rst), .ctl(ctl), .sts(sts),
    .cmd(cmd), .src_mode(src_mode), .src_reg(src_reg), .dst_mode(dst_mode),
    .dst_reg(dst_reg), .load_address(load_address), .load_data(load_data),
    .done(done), .status(status), .value(value),
    .flag_n(flag_n), .flag_z(flag_z), .flag_v(flag_v), .flag_c(flag_c)
  );

  `DOMC_ASSERT(a_done_after_busy, done |-> $past(busy), "done without work")
  `DOMC_ASSERT(a_err_zero, (done && status) |-> (value == 16'd0), "error value not zero")
  `DOMC_ASSERT(a_one_end, !(ctl.finish && ctl.error), "finish and error together")
endmodule
`default_nettype wire

### sv/domc_ctrl.sv
// ----------------------------------------------------------------------------
// domc_ctrl
// Sequencer: walks operand resolution one memory access at a time.
// ----------------------------------------------------------------------------
`default_nettype none
module domc_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  output logic                busy,
  input  wire domc_pkg::sts_t sts,
  output domc_pkg::ctl_t      ctl
);
  domc_pkg::state_t state, state_next, ret, ret_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= domc_pkg::ST_IDLE;
      ret   <= domc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
      ret   <= ret_next;
    end
  end

  // ST_WAIT covers the registered memory read, then returns to ret
  always_comb begin
    state_next = state;
    ret_next   = ret;
    case (state)
      domc_pkg::ST_IDLE: begin
        if (start) state_next = domc_pkg::ST_SRC_EA;
      end
      domc_pkg::ST_SRC_EA, domc_pkg::ST_DST_EA: begin
        // command loads and a mode-0 destination finish here; a mode-0 source moves on to the destination
        if (sts.cmd == domc_pkg::CmdLdm || sts.cmd == domc_pkg::CmdLdr) begin
          state_next = sts.odd ? domc_pkg::ST_ERR : domc_pkg::ST_FINISH;
        end else if (sts.mode == 3'd0) begin
          state_next = (state == domc_pkg::ST_SRC_EA) ? domc_pkg::ST_DST_EA
                                                      : domc_pkg::ST_FINISH;
        end else if (sts.mode == 3'd6 || sts.mode == 3'd7) begin
          state_next = sts.odd ? domc_pkg::ST_ERR : domc_pkg::ST_WAIT;
          ret_next   = (state == domc_pkg::ST_SRC_EA) ? domc_pkg::ST_SRC_IDX
                                                      : domc_pkg::ST_DST_IDX;
        end else if (sts.mode == 3'd3 || sts.mode == 3'd5) begin
          state_next = sts.odd ? domc_pkg::ST_ERR : domc_pkg::ST_WAIT;
          ret_next   = (state == domc_pkg::ST_SRC_EA) ? domc_pkg::ST_SRC_PTR
                                                      : domc_pkg::ST_DST_PTR;
        end else begin
          state_next = sts.odd ? domc_pkg::ST_ERR
                     : (state == domc_pkg::ST_SRC_EA) ? domc_pkg::ST_SRC_OPND
                     : domc_pkg::ST_DST_OPND;
        end
      end
      domc_pkg::ST_SRC_IDX, domc_pkg::ST_DST_IDX: begin
        if (sts.mode == 3'd7) begin
          state_next = sts.odd ? domc_pkg::ST_ERR : domc_pkg::ST_WAIT;
          ret_next   = (state == domc_pkg::ST_SRC_IDX) ? domc_pkg::ST_SRC_PTR
                                                       : domc_pkg::ST_DST_PTR;
        end else begin
          state_next = sts.odd ? domc_pkg::ST_ERR
                     : (state == domc_pkg::ST_SRC_IDX) ? domc_pkg::ST_SRC_OPND
                     : domc_pkg::ST_DST_OPND;
        end
      end
      domc_pkg::ST_SRC_PTR: begin
        state_next = sts.odd ? domc_pkg::ST_ERR : domc_pkg::ST_SRC_OPND;
      end
      domc_pkg::ST_DST_PTR: begin
        state_next = sts.odd ? domc_pkg::ST_ERR : domc_pkg::ST_DST_OPND;
      end
      domc_pkg::ST_SRC_OPND: begin
        state_next = domc_pkg::ST_WAIT;
        ret_next   = domc_pkg::ST_DST_EA;
      end
      domc_pkg::ST_DST_OPND: begin
        state_next = domc_pkg::ST_WAIT;
        ret_next   = domc_pkg::ST_FINISH;
      end
      domc_pkg::ST_WAIT:   state_next = ret;
      domc_pkg::ST_FINISH: state_next = domc_pkg::ST_IDLE;
      domc_pkg::ST_ERR:    state_next = domc_pkg::ST_IDLE;
      default:             state_next = domc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl  = '0;
    busy = (state != domc_pkg::ST_IDLE);
    case (state)
      domc_pkg::ST_IDLE:     ctl.load_cmd = start;
      domc_pkg::ST_SRC_EA:   ctl.ea_start = 1'b1;
      domc_pkg::ST_DST_EA: begin
        ctl.ea_start = 1'b1;
        ctl.dst_side = 1'b1;
      end
      domc_pkg::ST_SRC_IDX:  ctl.idx_fetch = 1'b1;
      domc_pkg::ST_DST_IDX: begin
        ctl.idx_fetch = 1'b1;
        ctl.dst_side  = 1'b1;
      end
      domc_pkg::ST_SRC_PTR:  ctl.ptr_fetch = 1'b1;
      domc_pkg::ST_DST_PTR: begin
        ctl.ptr_fetch = 1'b1;
        ctl.dst_side  = 1'b1;
      end
      domc_pkg::ST_SRC_OPND: ctl.opnd_fetch = 1'b1;
      domc_pkg::ST_DST_OPND: begin
        ctl.opnd_fetch = 1'b1;
        ctl.dst_side   = 1'b1;
      end
      domc_pkg::ST_FINISH:   ctl.finish = 1'b1;
      domc_pkg::ST_ERR:      ctl.error  = 1'b1;
      domc_pkg::ST_WAIT:     ctl = '0;
      default:               ctl = '0;
    endcase
  end
endmodule
`default_nettype wire

### sv/domc_dpath.sv
// ----------------------------------------------------------------------------
// domc_dpath
// Register file, working copy, word memory, flags and result registers.
// ----------------------------------------------------------------------------
`default_nettype none
module domc_dpath #(
  parameter int MEM_WORDS = domc_pkg::MemWordsDefault
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire domc_pkg::ctl_t ctl,
  output domc_pkg::sts_t      sts,
  input  wire logic [1:0]     cmd,
  input  wire logic [2:0]     src_mode,
  input  wire logic [2:0]     src_reg,
  input  wire logic [2:0]     dst_mode,
  input  wire logic [2:0]     dst_reg,
  input  wire logic [15:0]    load_address,
  input  wire logic [15:0]    load_data,
  output logic                done,
  output logic                status,
  output logic [15:0]         value,
  output logic                flag_n,
  output logic                flag_z,
  output logic                flag_v,
  output logic                flag_c
);
  localparam int AW = $clog2(MEM_WORDS);

  logic [15:0] rf [8];
  logic [15:0] wrf [8];
  logic [15:0] mem [MEM_WORDS];
  logic [15:0] rdata;
  logic [1:0]  c_cmd;
  logic [2:0]  c_sm, c_sr, c_dm, c_dr;
  logic [15:0] c_la, c_ld;
  logic [15:0] addr, src, dst;
  logic [3:0]  flags;

  logic [2:0]  mode, rsel;
  logic [15:0] rval, dec, ea_addr, fin_addr;
  logic [15:0] diff;
  logic        ovf, brw;
  logic [AW-1:0] mw_idx, mr_idx;
  logic        mw_en;
  logic [15:0] mw_data;
  logic        opnd_pend, opnd_dst;

  assign mode = ctl.dst_side ? c_dm : c_sm;
  assign rsel = ctl.dst_side ? c_dr : c_sr;
  assign rval = wrf[rsel];
  assign dec  = rval - 16'd2;

  // address the current state is about to use
  always_comb begin
    ea_addr = rval;
    if (mode == 3'd4 || mode == 3'd5) ea_addr = dec;
    if (mode == 3'd6 || mode == 3'd7) ea_addr = wrf[domc_pkg::RegPc];
  end

  always_comb begin
    sts.cmd  = c_cmd;
    sts.mode = mode;
    if (ctl.ea_start) begin
      if (c_cmd == domc_pkg::CmdLdm) sts.odd = c_la[0];
      else if (c_cmd == domc_pkg::CmdLdr) sts.odd = 1'b0;
      else sts.odd = ea_addr[0];
    end else if (ctl.idx_fetch) begin
      sts.odd = fin_addr[0];
    end else begin
      sts.odd = rdata[0];
    end
  end

  // index: register after PC has passed the index word
  assign fin_addr = ((rsel == domc_pkg::RegPc) ? wrf[domc_pkg::RegPc] + 16'd2 : rval)
                  + rdata;

  assign diff = src - dst;
  assign ovf  = (src[15] ^ dst[15]) & ~(diff[15] ^ dst[15]);
  assign brw  = src < dst;

  // single memory port: read and write address select
  always_comb begin
    mr_idx = addr[AW:1];
    if (ctl.ea_start) mr_idx = ea_addr[AW:1];
    mw_en   = 1'b0;
    mw_idx  = addr[AW:1];
    mw_data = src;
    if (ctl.finish && c_cmd == domc_pkg::CmdLdm) begin
      mw_en  = 1'b1;
      mw_idx = c_la[AW:1];
      mw_data = c_ld;
    end else if (ctl.finish && c_cmd == domc_pkg::CmdMov && c_dm != 3'd0) begin
      mw_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mw_en) mem[mw_idx] <= mw_data;
    rdata <= mem[mr_idx];
  end

  // operand read data lands in the cycle after the operand fetch, marked by opnd_pend
  always_ff @(posedge clk) begin
    if (rst) begin
      opnd_pend <= 1'b0;
      opnd_dst  <= 1'b0;
    end else begin
      opnd_pend <= ctl.opnd_fetch;
      opnd_dst  <= ctl.dst_side;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_cmd) begin
      c_cmd <= cmd;
      c_sm  <= src_mode;
      c_sr  <= src_reg;
      c_dm  <= dst_mode;
      c_dr  <= dst_reg;
      c_la  <= load_address;
      c_ld  <= load_data;
    end
    if (ctl.ea_start) begin
      addr <= ea_addr;
      if (mode == 3'd0) begin
        if (ctl.dst_side) dst <= rval;
        else src <= rval;
      end
    end
    if (ctl.idx_fetch) addr <= fin_addr;
    if (ctl.ptr_fetch) addr <= rdata;
    // capture the read operand
    if (opnd_pend) begin
      if (opnd_dst) dst <= rdata;
      else src <= rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) begin
        rf[i]  <= '0;
        wrf[i] <= '0;
      end
      flags <= '0;
      done  <= 1'b0;
    end else begin
      done <= ctl.finish | ctl.error;
      if (ctl.load_cmd) wrf <= rf;
      if (ctl.ea_start && c_cmd[1] == 1'b0) begin
        if (mode == 3'd2 || mode == 3'd3) wrf[rsel] <= rval + 16'd2;
        if (mode == 3'd4 || mode == 3'd5) wrf[rsel] <= dec;
      end
      if (ctl.idx_fetch) wrf[domc_pkg::RegPc] <= wrf[domc_pkg::RegPc] + 16'd2;
      if (ctl.finish) begin
        case (c_cmd)
          domc_pkg::CmdLdr: rf[c_la[2:0]] <= c_ld;
          domc_pkg::CmdLdm: ;
          domc_pkg::CmdMov: begin
            for (int i = 0; i < 8; i++)
              rf[i] <= (c_dm == 3'd0 && c_dr == 3'(i)) ? src : wrf[i];
            flags <= {src[15], src == 16'd0, 1'b0, flags[0]};
          end
          domc_pkg::CmdCmp: begin
            rf <= wrf;
            flags <= {diff[15], diff == 16'd0, ovf, brw};
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.error) begin
      status <= 1'b1;
      value  <= '0;
    end else begin
      status <= 1'b0;
      value  <= (c_cmd[1]) ? c_ld : (c_cmd == domc_pkg::CmdMov) ? src : dst;
    end
  end

  assign {flag_n, flag_z, flag_v, flag_c} = flags;
endmodule
`default_nettype wire
